// ===== rtl/amg_pkg.sv =====
// Shared constants, types and helpers for the adjacency matrix graph store.
package amg_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int IDX_W       = 7;
    localparam int NB_W        = 6;
    localparam int RESULT_CAP  = 64;
    localparam int CNT_W       = $clog2(RESULT_CAP);
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_DIRECTED   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW_A,
        ST_ROW_B,
        ST_LIST
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] active;
        logic             directed;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic              a_ok;
        logic              b_ok;
    } t_cmd;

    typedef struct packed {
        logic            success;
        logic [NB_W-1:0] neighbor;
        logic            last;
    } t_result;

    function automatic logic [NODE_W-1:0] to_node(input logic [IDX_W-1:0] v);
        return NODE_W'(v);
    endfunction

endpackage

// ===== rtl/amg_front.sv =====
// Front end: configuration registers, input handshake and command classification.
module amg_front
    import amg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [15:0]           i_s_tdata,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    output t_cfg                  o_cfg
);

    logic [IDX_W-1:0] r_node_count;
    logic             r_directed;
    logic [IDX_W-1:0] active;
    logic [IDX_W-1:0] from_node;
    logic [IDX_W-1:0] to_node_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= IDX_W'(64);
            r_directed   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                CFG_DIRECTED:   r_directed   <= i_cfg_data[0];
            endcase
        end
    end

    // saturate the node count at the matrix size
    assign active = (32'(r_node_count) < 32'(MAX_NODES)) ? r_node_count : IDX_W'(MAX_NODES);

    assign o_cfg.active   = active;
    assign o_cfg.directed = r_directed;

    assign from_node  = i_s_tdata[8:2];
    assign to_node_in = i_s_tdata[15:9];

    assign o_s_tready = i_q_ready;
    assign o_push     = i_s_tvalid && i_q_ready;

    always_comb begin
        o_cmd.op   = t_op'(i_s_tdata[1:0]);
        o_cmd.a    = to_node(from_node);
        o_cmd.b    = to_node(to_node_in);
        o_cmd.a_ok = from_node < active;
        o_cmd.b_ok = to_node_in < active;
    end

endmodule

// ===== rtl/amg_queue.sv =====
// Short command queue between the front end and the matrix engine.
module amg_queue
    import amg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign o_ready = r_fill != FILL_W'(QUEUE_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_cmd   = r_slot[r_rd_ptr];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) r_wr_ptr <= bump(r_wr_ptr);
            if (pop)  r_rd_ptr <= bump(r_rd_ptr);
            if (push && !pop)      r_fill <= r_fill + 1'b1;
            else if (pop && !push) r_fill <= r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wr_ptr] <= i_cmd;
    end

endmodule

// ===== rtl/amg_back.sv =====
// Matrix engine: edge row memory, operation sequencer and result register.
module amg_back
    import amg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_result o_result
);

    logic [MAX_NODES-1:0] mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_row_valid;
    logic [MAX_NODES-1:0] r_rd_data;
    logic                 r_rd_valid;

    t_state               r_state, n_state;
    t_cmd                 r_cmd;
    logic [MAX_NODES-1:0] r_mask, n_mask;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    logic                 r_out_valid;
    t_result              r_out;

    logic                 rd_en;
    logic [NODE_W-1:0]    rd_addr;
    logic                 we;
    logic [NODE_W-1:0]    wr_addr;
    logic [MAX_NODES-1:0] wr_data;

    logic                 out_free;
    logic                 emit;
    t_result              emit_res;

    logic [MAX_NODES-1:0] row;
    logic [MAX_NODES-1:0] lim;
    logic [NODE_W-1:0]    bit_idx;
    logic [MAX_NODES-1:0] bit_oh;
    logic [MAX_NODES-1:0] row_next;
    logic                 is_insert;
    logic                 edge_bit;
    logic                 single_ok;
    logic                 do_write;
    logic [NODE_W-1:0]    first_idx;
    logic [MAX_NODES-1:0] rest;

    function automatic logic [NODE_W-1:0] lowest_set(input logic [MAX_NODES-1:0] m);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (m[i]) idx = NODE_W'(i);
        end
        return idx;
    endfunction

    // a row never written since reset reads as empty
    assign row = r_rd_valid ? r_rd_data : '0;

    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            lim[j] = 32'(j) < 32'(i_cfg.active);
        end
    end

    assign is_insert = r_cmd.op == OP_INSERT;
    assign bit_idx   = (r_state == ST_ROW_B) ? r_cmd.a : r_cmd.b;
    assign bit_oh    = {{(MAX_NODES-1){1'b0}}, 1'b1} << bit_idx;
    assign row_next  = is_insert ? (row | bit_oh) : (row & ~bit_oh);
    assign edge_bit  = (row & bit_oh) != '0;
    assign single_ok = r_cmd.a_ok && r_cmd.b_ok && (is_insert ? !edge_bit : edge_bit);
    assign do_write  = single_ok && (r_cmd.op == OP_INSERT || r_cmd.op == OP_REMOVE);
    assign first_idx = lowest_set(r_mask);
    assign rest      = r_mask & ~({{(MAX_NODES-1){1'b0}}, 1'b1} << first_idx);
    assign out_free  = !r_out_valid || i_m_tready;

    always_comb begin
        n_state  = r_state;
        n_mask   = r_mask;
        n_cnt    = r_cnt;
        rd_en    = 1'b0;
        rd_addr  = i_q_cmd.a;
        we       = 1'b0;
        wr_addr  = r_cmd.a;
        wr_data  = row_next;
        emit     = 1'b0;
        emit_res = '{success: 1'b0, neighbor: '0, last: 1'b1};
        o_q_pop  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    rd_en   = 1'b1;
                    n_state = ST_ROW_A;
                end
            end
            ST_ROW_A: begin
                if (r_cmd.op == OP_LIST) begin
                    n_mask  = r_cmd.a_ok ? (row & lim) : '0;
                    n_cnt   = '0;
                    n_state = ST_LIST;
                end else if (out_free) begin
                    emit             = 1'b1;
                    emit_res.success = single_ok;
                    we               = do_write;
                    // undirected write: fetch the mirror row next
                    if (do_write && !i_cfg.directed) begin
                        rd_en   = 1'b1;
                        rd_addr = r_cmd.b;
                        n_state = ST_ROW_B;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ROW_B: begin
                we      = 1'b1;
                wr_addr = r_cmd.b;
                n_state = ST_IDLE;
            end
            ST_LIST: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_mask == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        emit_res.success  = 1'b1;
                        emit_res.neighbor = NB_W'(first_idx);
                        emit_res.last     = (rest == '0) || (r_cnt == CNT_W'(RESULT_CAP - 1));
                        n_mask            = rest;
                        n_cnt             = r_cnt + 1'b1;
                        if (emit_res.last) n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) r_row_valid[wr_addr] <= 1'b1;
            if (emit)            r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data  <= mem[rd_addr];
            r_rd_valid <= r_row_valid[rd_addr];
        end
        if (we) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_q_cmd;
        r_mask <= n_mask;
        r_cnt  <= n_cnt;
        if (emit) r_out <= emit_res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

    a_mirror_after_row_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROW_B |-> $past(r_state) == ST_ROW_A)
        else $error("mirror write without a primary row step");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == ST_ROW_A || r_state == ST_ROW_B))
        else $error("row memory written outside an edge update");

    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && !emit_res.success |-> emit_res.last)
        else $error("failed result not marked last");

    a_list_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LIST && emit && emit_res.last |=> r_state == ST_IDLE)
        else $error("listing did not finish after its last word");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result overwrote a word still waiting");

endmodule

// ===== rtl/adjacency_matrix_graph.sv =====
// Adjacency matrix graph store: top level joining front end, queue and engine.
//
// Commands enter on the s_axis channel, one per word: tdata holds opcode [1:0],
// from_node [8:2] and to_node [15:9]. Results leave on m_axis: tdata holds
// success [0] and neighbor [6:1] (bit 7 zero), tlast marks the final result
// of a command. Configuration registers (node count, directed mode) are
// written through i_cfg_we / i_cfg_index / i_cfg_data; the user must write
// them only while no work is open, as the block does not enforce this.
// Insert, remove and query give one result each. The engine steps through idle
// and row-A for a query, failed or directed update, adds row-B for an undirected
// successful update (the mirror row needs its own read-modify-write), and for a
// listing goes on to the list state (one priority-encoded neighbor per cycle
// while m_axis takes them, at least one result). A two-word command queue lets
// the front keep accepting while the engine works. Reset empties the matrix at
// once through per-row valid bits (no clearing pass), sets node count to 64 and
// undirected mode. When m_axis_tready is low the result register holds, the
// engine waits, the queue fills and s_axis_tready drops.
module adjacency_matrix_graph
    import amg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // opcode, from_node, to_node
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // success, neighbor, zero pad
    output logic                  m_axis_tlast
);

    t_cfg    cfg;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    q_ready;
    logic    q_valid;
    logic    q_pop;
    t_result result;

    amg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_cfg       (cfg)
    );

    amg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    amg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (head_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tdata = {1'b0, result.neighbor, result.success};
    assign m_axis_tlast = result.last;

endmodule
